FILE: hw/rtl/tedq_pkg.sv
`timescale 1ns / 1ps

package tedq_pkg;

    // operation codes of an input word
    typedef enum logic {
        OP_ADD     = 1'b0,
        OP_COLLECT = 1'b1
    } op_e;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ADD_STATUS = 2'd0,
        KIND_RELEASED   = 2'd1,
        KIND_NONE_READY = 2'd2
    } kind_e;

    // add status codes
    typedef enum logic [1:0] {
        ST_ACCEPTED  = 2'd0,
        ST_DROPPED   = 2'd1,
        ST_DISMISSED = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_e;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_QUEUE_LIMIT    = 2'd0,
        REG_TRAINING_DELAY = 2'd1,
        REG_CLOCK_PERIOD   = 2'd2
    } reg_e;

    typedef struct packed {
        logic        operation;
        logic [63:0] current_time;
        logic [1:0]  source_cache;
        logic [1:0]  target_cache;
        logic [63:0] address;
        logic [1:0]  event_type;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [1:0]  add_status;
        logic [63:0] ready_time;
        logic [1:0]  event_source;
        logic [1:0]  event_target;
        logic [63:0] event_address;
        logic [1:0]  event_kind;
        logic        last;
    } out_word_t;

    // one stored event
    typedef struct packed {
        logic [63:0] ready_time;
        logic [63:0] address;
        logic [1:0]  target;
        logic [1:0]  kind;
    } slot_t;

endpackage

FILE: hw/rtl/tedq_slot_ram.sv
`timescale 1ns / 1ps

// Event slot storage: one write port, one read port, registered read.
module tedq_slot_ram
    import tedq_pkg::*;
#(
    parameter int AW = 5
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  slot_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output slot_t         rd_data
);

    slot_t mem [0:(1 << AW) - 1];
    slot_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/training_event_queue_distributor.sv
`timescale 1ns / 1ps

// Training event queue distributor.
// Holds one bounded FIFO of timed training events per source cache, all kept
// in a single slot RAM addressed by {source, position}.
// Command channel: an input word is taken when start is high and busy is
// low. An add word stamps ready time = now + clock_period*(occupancy +
// training_delay), stores it and returns one status word. A collect word
// releases every entry whose ready time lies before now, source by source,
// oldest first, flagging the final word with last (or returns one
// nothing-ready word).
// Config channel: cfg_valid/cfg_ready with cfg_index/cfg_data; always ready.
// Write it only while busy is low and no result is still due.
// Results: each word sits on result for one cycle with result_valid high;
// the receiver cannot stall, so there is no backpressure path.
// Sequence: an add holds busy through the queue update and 16x17 multiply,
// then the 64-bit add and RAM write; a dismissed or rejected add ends after
// the first step. A collect walks the sources in turn; each head check waits
// on the registered RAM read. A result is registered and shows in the cycle
// after it is decided.
// Reset clears heads, counts, same-tick marks and the working tick; slots are
// undefined until written and only data of occupied slots is used.
module training_event_queue_distributor
    import tedq_pkg::*;
#(
    parameter int NUM_SOURCES = 4,
    parameter int DEPTH       = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_word_t    item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output out_word_t   result,
    output logic        result_valid
);

    localparam int SW = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = $clog2(NUM_SOURCES + 1);
    localparam int XW = ((CW > 4) ? CW : 4) + 1;
    localparam int AW = SW + PW;

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_ADD_CALC  = 6'b000010,
        S_ADD_WRITE = 6'b000100,
        S_COL_RD    = 6'b001000,
        S_COL_CHK   = 6'b010000,
        S_COL_END   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [3:0]  limit_reg;
    logic [15:0] delay_reg;
    logic [15:0] period_reg;

    // queue bookkeeping
    logic [PW-1:0] head_reg  [NUM_SOURCES];
    logic [PW-1:0] head_next [NUM_SOURCES];
    logic [CW-1:0] count_reg [NUM_SOURCES];
    logic [CW-1:0] count_next[NUM_SOURCES];
    logic [NUM_SOURCES-1:0] added_reg, added_next;
    logic [63:0] tick_reg, tick_next;

    // current word and working registers
    in_word_t      item_reg;
    logic [32:0]   prod_reg, prod_next;
    logic [PW-1:0] pos_reg, pos_next;
    logic [1:0]    status_reg, status_next;
    logic [WW-1:0] walk_reg, walk_next;
    out_word_t     pend_reg, pend_next;
    logic          pend_valid_reg, pend_valid_next;
    out_word_t     result_reg, result_next;
    logic          result_valid_reg, result_valid_next;

    // slot RAM
    logic    wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    slot_t   wr_data, rd_data;

    // add datapath
    logic          accept;
    logic          collecting;
    logic [SW-1:0] src_idx, sel_idx;
    logic          src_bad;
    logic          limited;
    logic [PW-1:0] head_cur;
    logic [CW-1:0] count_cur;
    logic [XW-1:0] cnt_x, lim_x, cnt_eff, drop;
    logic          do_drop, full;
    logic [PW:0]   head_sum, pos_sum;
    logic [PW-1:0] head_new, pos_new, head_inc;
    logic [16:0]   mult_in;
    logic [32:0]   prod;
    logic          walk_done;
    logic          head_ready;

    assign accept     = start && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign cfg_ready  = 1'b1;
    assign collecting = (state_reg == S_COL_RD) || (state_reg == S_COL_CHK);

    assign src_idx = SW'(item_reg.source_cache);
    assign src_bad = (int'(item_reg.source_cache) >= NUM_SOURCES);
    assign sel_idx = collecting ? walk_reg[SW-1:0] : src_idx;
    assign head_cur  = head_reg[sel_idx];
    assign count_cur = count_reg[sel_idx];
    assign limited   = (limit_reg != 4'd0);

    // full queue in limited mode: trim down to limit-1 entries
    always_comb
    begin
        cnt_x   = XW'(count_cur);
        lim_x   = XW'(limit_reg);
        do_drop = limited && (cnt_x >= lim_x);
        cnt_eff = do_drop ? (lim_x - XW'(1)) : cnt_x;
        drop    = cnt_x - cnt_eff;
        head_sum = (PW+1)'(head_cur) + (PW+1)'(drop);
        head_new = (head_sum >= (PW+1)'(DEPTH)) ? PW'(head_sum - (PW+1)'(DEPTH))
                                                : PW'(head_sum);
        full     = (cnt_eff >= XW'(DEPTH));
        pos_sum  = (PW+1)'(head_new) + (PW+1)'(cnt_eff);
        pos_new  = (pos_sum >= (PW+1)'(DEPTH)) ? PW'(pos_sum - (PW+1)'(DEPTH))
                                               : PW'(pos_sum);
        mult_in  = 17'(cnt_eff) + 17'(delay_reg);
        prod     = {17'd0, period_reg} * {16'd0, mult_in};
        head_inc = (head_cur == PW'(DEPTH - 1)) ? '0 : head_cur + PW'(1);
    end

    assign walk_done  = (walk_reg == WW'(NUM_SOURCES));
    assign head_ready = (rd_data.ready_time < item_reg.current_time);

    // RAM ports
    assign rd_addr = {walk_reg[SW-1:0], head_cur};
    assign wr_en   = (state_reg == S_ADD_WRITE);
    assign wr_addr = {src_idx, pos_reg};
    always_comb
    begin
        wr_data.ready_time = item_reg.current_time + 64'(prod_reg);
        wr_data.address    = item_reg.address;
        wr_data.target     = item_reg.target_cache;
        wr_data.kind       = item_reg.event_type;
    end

    always_comb
    begin
        state_next        = state_reg;
        head_next         = head_reg;
        count_next        = count_reg;
        added_next        = added_reg;
        tick_next         = tick_reg;
        prod_next         = prod_reg;
        pos_next          = pos_reg;
        status_next       = status_reg;
        walk_next         = walk_reg;
        pend_next         = pend_reg;
        pend_valid_next   = pend_valid_reg;
        result_next       = '0;
        result_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (item.operation == OP_COLLECT)
                    begin
                        walk_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_COL_RD;
                    end
                    else
                    begin
                        // new tick: forget who added already
                        if (item.current_time != tick_reg)
                        begin
                            added_next = '0;
                            tick_next  = item.current_time;
                        end
                        state_next = S_ADD_CALC;
                    end
                end
            end

            S_ADD_CALC:
            begin
                result_next.result_kind = KIND_ADD_STATUS;
                result_next.last        = 1'b1;
                if (src_bad)
                begin
                    result_next.add_status = ST_OVERFLOW;
                    result_valid_next      = 1'b1;
                    state_next             = S_IDLE;
                end
                else if (limited && added_reg[src_idx])
                begin
                    result_next.add_status = ST_DISMISSED;
                    result_valid_next      = 1'b1;
                    state_next             = S_IDLE;
                end
                else
                begin
                    head_next[src_idx] = head_new;
                    if (full)
                    begin
                        count_next[src_idx]    = CW'(cnt_eff);
                        result_next.add_status = ST_OVERFLOW;
                        result_valid_next      = 1'b1;
                        state_next             = S_IDLE;
                    end
                    else
                    begin
                        count_next[src_idx] = CW'(cnt_eff + XW'(1));
                        if (limited)
                        begin
                            added_next[src_idx] = 1'b1;
                        end
                        prod_next   = prod;
                        pos_next    = pos_new;
                        status_next = do_drop ? ST_DROPPED : ST_ACCEPTED;
                        state_next  = S_ADD_WRITE;
                    end
                end
            end

            S_ADD_WRITE:
            begin
                result_next.result_kind = KIND_ADD_STATUS;
                result_next.add_status  = status_reg;
                result_next.ready_time  = wr_data.ready_time;
                result_next.last        = 1'b1;
                result_valid_next       = 1'b1;
                state_next              = S_IDLE;
            end

            S_COL_RD:
            begin
                if (walk_done)
                begin
                    state_next = S_COL_END;
                end
                else if (count_cur == '0)
                begin
                    walk_next = walk_reg + WW'(1);
                end
                else
                begin
                    // head slot read issued this cycle
                    state_next = S_COL_CHK;
                end
            end

            S_COL_CHK:
            begin
                if (head_ready)
                begin
                    // hold one word back so the final one can carry last
                    if (pend_valid_reg)
                    begin
                        result_next       = pend_reg;
                        result_valid_next = 1'b1;
                    end
                    pend_next                = '0;
                    pend_next.result_kind    = KIND_RELEASED;
                    pend_next.ready_time     = rd_data.ready_time;
                    pend_next.event_source   = 2'(walk_reg);
                    pend_next.event_target   = rd_data.target;
                    pend_next.event_address  = rd_data.address;
                    pend_next.event_kind     = rd_data.kind;
                    pend_valid_next          = 1'b1;
                    head_next[sel_idx]       = head_inc;
                    count_next[sel_idx]      = count_cur - CW'(1);
                end
                else
                begin
                    walk_next = walk_reg + WW'(1);
                end
                state_next = S_COL_RD;
            end

            S_COL_END:
            begin
                if (pend_valid_reg)
                begin
                    result_next = pend_reg;
                end
                else
                begin
                    result_next.result_kind = KIND_NONE_READY;
                end
                result_next.last  = 1'b1;
                result_valid_next = 1'b1;
                pend_valid_next   = 1'b0;
                state_next        = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            limit_reg        <= 4'd0;
            delay_reg        <= 16'd1;
            period_reg       <= 16'd1;
            added_reg        <= '0;
            tick_reg         <= '0;
            walk_reg         <= '0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_SOURCES; i++)
            begin
                head_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            added_reg        <= added_next;
            tick_reg         <= tick_next;
            walk_reg         <= walk_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
            head_reg         <= head_next;
            count_reg        <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_QUEUE_LIMIT:    limit_reg  <= cfg_data[3:0];
                    REG_TRAINING_DELAY: delay_reg  <= cfg_data;
                    REG_CLOCK_PERIOD:   period_reg <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
        prod_reg   <= prod_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    tedq_slot_ram #(
        .AW (AW)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule
